@@ rtl/core/hcbp_pkg.sv @@
// Shared types and constants of the Huffman code bit packer.
// No dependencies; the lookup, packer and top files import this package.
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int SYM_W     = 7;   // symbol / table index
  localparam int CODE_W    = 31;  // widest code the port carries
  localparam int LEN_W     = 5;   // code length field
  localparam int BYTE_W    = 8;
  localparam int PEND_W    = 7;   // at most seven bits wait for the next byte
  localparam int CNT_W     = 3;   // pending bit count
  localparam int ACC_W     = PEND_W + CODE_W;  // pending bits plus one code
  localparam int TOT_W     = 6;   // up to 38 bits in the accumulator
  localparam int WIN_W     = 40;  // accumulator left-aligned on whole bytes
  localparam int NB_W      = 3;   // up to five bytes per word
  localparam int IN_DATA_W = 48;  // symbol, code, length padded to bytes

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_ENCODE = 1'b1
  } hcbp_op_t;

  localparam logic [SYM_W-1:0] END_SYMBOL = '0;

  // Looked-up code of one encode word, handed from lookup to packer.
  typedef struct packed {
    logic              is_end;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } hcbp_sym_t;

endpackage

@@ rtl/core/hcbp_lookup.sv @@
// Code table and lookup register of the Huffman code bit packer.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_lookup #(
  parameter int SYMBOL_COUNT = 128,
  parameter int MAX_CODE_LEN = 31
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
  input  logic [hcbp_pkg::CODE_W-1:0] entry_code,
  input  logic [hcbp_pkg::LEN_W-1:0]  entry_length,
  input  hcbp_pkg::hcbp_op_t          opcode,
  output logic                        sym_valid,
  input  logic                        sym_ready,
  output hcbp_pkg::hcbp_sym_t         sym
);
  import hcbp_pkg::*;

  localparam int AW        = (SYMBOL_COUNT > 2) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_CLAMP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int CW        = LEN_CLAMP;

  logic [CW-1:0]           code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld_r;

  logic              s1_valid_r, s1_valid_nxt;
  logic [CW-1:0]     code_r;
  logic [LEN_W-1:0]  len_r;
  logic              hit_r;
  logic              end_r;

  logic              in_fire, wr_en, rd_en, in_range;
  logic [AW-1:0]     addr;
  logic [LEN_W-1:0]  len_sat;

  assign in_tready = !s1_valid_r || sym_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign in_range  = (32'(symbol) < SYMBOL_COUNT);
  assign addr      = AW'(symbol);
  assign wr_en     = in_fire && (opcode == OP_WRITE) && in_range;
  assign rd_en     = in_fire && (opcode == OP_ENCODE);
  assign len_sat   = (entry_length > LEN_W'(LEN_CLAMP)) ? LEN_W'(LEN_CLAMP) : entry_length;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (rd_en) begin
      s1_valid_nxt = 1'b1;
    end else if (sym_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Table storage: write and registered read on the accept edge.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[addr] <= entry_code[CW-1:0];
      len_mem[addr]  <= len_sat;
    end
    if (rd_en) begin
      code_r <= code_mem[addr];
      len_r  <= len_mem[addr];
      end_r  <= (symbol == END_SYMBOL);
    end
  end

  // Entries never written read as zero length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      hit_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= in_range && vld_r[addr];
      end
    end
  end

  assign sym_valid   = s1_valid_r;
  assign sym.is_end  = end_r;
  assign sym.len     = hit_r ? len_r : '0;
  assign sym.code    = hit_r ? CODE_W'(code_r) : '0;

endmodule

@@ rtl/core/hcbp_pack.sv @@
// Bit accumulator and byte output register of the Huffman code bit packer.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_pack (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        sym_valid,
  output logic                        sym_ready,
  input  hcbp_pkg::hcbp_sym_t         sym,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [hcbp_pkg::BYTE_W-1:0] out_tdata,
  output logic                        out_tlast,
  output logic                        out_tuser
);
  import hcbp_pkg::*;

  logic [PEND_W-1:0] pend_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [WIN_W-1:0]  win_r;
  logic [NB_W-1:0]   nb_r, idx_r;
  logic              end_r, dvalid_r;

  logic [CODE_W-1:0] code_m;
  logic [ACC_W-1:0]  acc;
  logic [TOT_W-1:0]  total;
  logic [CNT_W-1:0]  rem;
  logic [NB_W-1:0]   nbytes;
  logic [WIN_W-1:0]  win;
  logic [BYTE_W-1:0] rem_mask;
  logic              last_hs, drain_free, fire;

  // Append the code behind the pending bits.
  assign code_m = sym.code & ((CODE_W'(1) << sym.len) - CODE_W'(1));
  assign acc    = (ACC_W'(pend_r) << sym.len) | ACC_W'(code_m);
  assign total  = TOT_W'(cnt_r) + TOT_W'(sym.len);
  assign rem    = total[CNT_W-1:0];
  assign nbytes = NB_W'(total[TOT_W-1:3]) + NB_W'(sym.is_end && (rem != '0));
  // Left-align so every output byte is a fixed slice; flush pads with zeros.
  assign win      = WIN_W'(acc) << (TOT_W'(WIN_W) - total);
  assign rem_mask = (BYTE_W'(1) << rem) - BYTE_W'(1);

  assign last_hs    = dvalid_r && out_tready && (idx_r == nb_r - NB_W'(1));
  assign drain_free = !dvalid_r || last_hs;
  assign sym_ready  = drain_free || (nbytes == '0);
  assign fire       = sym_valid && sym_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      cnt_r    <= '0;
      dvalid_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      if (fire) begin
        if (sym.is_end) begin
          pend_r <= '0;
          cnt_r  <= '0;
        end else begin
          pend_r <= acc[PEND_W-1:0] & rem_mask[PEND_W-1:0];
          cnt_r  <= rem;
        end
      end
      if (fire && (nbytes != '0)) begin
        dvalid_r <= 1'b1;
        idx_r    <= '0;
      end else if (last_hs) begin
        dvalid_r <= 1'b0;
      end else if (dvalid_r && out_tready) begin
        idx_r <= idx_r + NB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (nbytes != '0)) begin
      win_r <= win;
      nb_r  <= nbytes;
      end_r <= sym.is_end;
    end
  end

  always_comb begin
    case (idx_r)
      3'd0:    out_tdata = win_r[39:32];
      3'd1:    out_tdata = win_r[31:24];
      3'd2:    out_tdata = win_r[23:16];
      3'd3:    out_tdata = win_r[15:8];
      3'd4:    out_tdata = win_r[7:0];
      default: out_tdata = '0;
    endcase
  end

  assign out_tvalid = dvalid_r;
  assign out_tlast  = (idx_r == nb_r - NB_W'(1));
  assign out_tuser  = end_r && out_tlast;

endmodule

@@ rtl/core/huffman_code_bit_packer_top.sv @@
// Top level of the table-driven Huffman code bit packer.
// Depends on hcbp_pkg, hcbp_lookup and hcbp_pack.
`timescale 1ns / 1ps

// Usage:
//   in_*  : one word per symbol or table write. in_tuser is the opcode
//           (write entry / encode symbol); in_tdata carries symbol, code
//           bits and code length. Encoding symbol zero ends the stream:
//           its code is appended and a partial byte flushes, zero padded.
//   out_* : one packed byte per word, earliest code bit in bit 7.
//           out_tlast marks the last byte caused by one input word,
//           out_tuser marks the final byte of a stream.
// Path: an accepted encode word passes the table read register, then the
//   byte output register, before its first byte shows.
// Throughput: one word per cycle while out_tready is high and each word
//   yields at most one byte; a word yielding more bytes holds the
//   output register, which moves one byte per handshake. Table writes and
//   words with no byte pass at one per cycle behind the lookup register.
// Reset: clears the pending bits and every table entry at once through
//   per-entry valid bits (no clearing pass); the block is ready the cycle
//   after reset releases.
// Stall: when out_tready is low the byte holds, an encode word yielding
//   bytes waits in the lookup register; in_tready drops once it is full.
module huffman_code_bit_packer_top #(
  parameter int SYMBOL_COUNT = 128,
  parameter int MAX_CODE_LEN = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [6:0] symbol, [37:7] entry_code,
                                  // [42:38] entry_length, [47:43] zero
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] packed_byte
  output logic        out_tlast,  // last_of_run
  output logic        out_tuser   // [0] stream_end
);
  import hcbp_pkg::*;

  logic       sym_valid, sym_ready;
  hcbp_sym_t  sym;
  hcbp_op_t   opcode;

  assign opcode = hcbp_op_t'(in_tuser);

  // Table lookup: write entries, read the code of each encode word.
  hcbp_lookup #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_lookup (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .symbol       (in_tdata[6:0]),
    .entry_code   (in_tdata[37:7]),
    .entry_length (in_tdata[42:38]),
    .opcode       (opcode),
    .sym_valid    (sym_valid),
    .sym_ready    (sym_ready),
    .sym          (sym)
  );

  // Append code bits, cut whole bytes, drain them one per handshake.
  hcbp_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .sym_valid  (sym_valid),
    .sym_ready  (sym_ready),
    .sym        (sym),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

@@ rtl/core/hcbp_checker.sv @@
// Port-level checks of the Huffman code bit packer, bound to the top level.
// Depends on huffman_code_bit_packer_top for the bind target.
`timescale 1ns / 1ps

module hcbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // Stream end only ever sits on the last byte of a word.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser || out_tlast))
    else $error("stream end flagged on a byte that is not last of run");

  // No byte survives reset.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      ($stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("output word changed while stalled");

endmodule

bind huffman_code_bit_packer_top hcbp_checker u_hcbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
